// ----- rtl/ptsr_pkg.sv -----
package ptsr_pkg;
   localparam int TABLE_DEPTH = 128;
   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int TIME_W = 63;
   localparam int NUM_W = 47;
   localparam int RATE_W = 32;
   localparam logic [29:0] US_PER_S_MILLI = 30'd1000000000;
   localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_INVALID = 2'd1,
      ST_FULL    = 2'd2
   } status_type;

   typedef struct packed {
      logic [47:0] station_code;
      logic [55:0] other_code;
      logic [15:0] sample_count;
      logic [RATE_W-1:0] sample_rate_mhz;
      logic [TIME_W-1:0] current_time_us;
   } item_type;

   typedef struct packed {
      logic [TIME_W-1:0] start_time_us;
      logic [TIME_W-1:0] end_time_us;
      status_type status;
      logic entry_created;
   } result_type;
endpackage

// ----- rtl/per_channel_timestamp_regenerator_unit.sv -----
// Per-channel timestamp regenerator. Each request word carries a packet header; the block
// searches its channel table linearly, reading and then comparing one entry at a time, through
// a memory with a registered read port, creates an entry for an unknown key if room is left,
// and answers with the channel's running start time, start plus (count-1)*1e9/rate
// microseconds as the end time (saturating), a status and a created flag. The linear table
// search and a 47-step restoring divider set the time one word takes. One word is worked on
// at a time; a finished response waits in the output register while the next word is taken
// in and worked on. Invalid packets skip the search and the divider.
module per_channel_timestamp_regenerator_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // station_code[47:0], channel_code[71:48], network_code[87:72], location_code[103:88],
   // sample_count[119:104], sample_rate_mhz[151:120], current_time_us[214:152], zero pad
   input  logic [215:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // start_time_us[62:0], end_time_us[125:63], status[127:126], entry_created[128], zero pad
   output logic [135:0] rsp_tdata
);
   import ptsr_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_SEARCH = 7'b0000010,
      S_CHECK  = 7'b0000100,
      S_DIV    = 7'b0001000,
      S_READ   = 7'b0010000,
      S_WRITE  = 7'b0100000,
      S_OUT    = 7'b1000000
   } state_type;

   logic [47:0]       sta_mem [TABLE_DEPTH];
   logic [55:0]       oth_mem [TABLE_DEPTH];
   logic [TIME_W-1:0] time_mem [TABLE_DEPTH];

   state_type state_ff, state_in;
   item_type item_ff, item_in;
   result_type res_ff, res_in;
   result_type fin_ff, fin_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0] used_ff, used_in;
   logic [CNT_W-1:0] scan_ff, scan_in;
   logic [IDX_W-1:0] slot_ff, slot_in;
   logic created_ff, created_in;
   logic rd_pending_ff, rd_pending_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [NUM_W-1:0] num_ff, num_in;
   logic [RATE_W:0] rem_ff, rem_in;
   logic [5:0] step_ff, step_in;

   logic [47:0] sta_rd_ff;
   logic [55:0] oth_rd_ff;
   logic [TIME_W-1:0] time_rd_ff;
   logic [IDX_W-1:0] rd_addr;
   logic mem_we;
   logic [IDX_W-1:0] wr_addr;
   logic [TIME_W-1:0] wr_time;
   logic key_wr;

   logic [RATE_W:0] rem_sh;
   logic [TIME_W:0] end_sum;
   logic [46:0] prod;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {7'd0, res_ff.entry_created, res_ff.status,
                       res_ff.end_time_us, res_ff.start_time_us};

   assign prod = 47'({15'd0, item_ff.sample_count - 16'd1} * {17'd0, US_PER_S_MILLI});
   assign rem_sh = {rem_ff[RATE_W-1:0], num_ff[NUM_W-1]};
   assign end_sum = {1'b0, time_rd_ff} + {17'd0, quo_ff};

   always_comb begin
      state_in = state_ff;
      item_in = item_ff;
      res_in = res_ff;
      fin_in = fin_ff;
      rsp_valid_in = rsp_valid_ff;
      used_in = used_ff;
      scan_in = scan_ff;
      slot_in = slot_ff;
      created_in = created_ff;
      rd_pending_in = 1'b0;
      quo_in = quo_ff;
      num_in = num_ff;
      rem_in = rem_ff;
      step_in = step_ff;
      rd_addr = scan_ff[IDX_W-1:0];
      mem_we = 1'b0;
      key_wr = 1'b0;
      wr_addr = slot_ff;
      wr_time = item_ff.current_time_us;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               item_in.station_code = req_tdata[47:0];
               item_in.other_code = {req_tdata[71:48], req_tdata[87:72], req_tdata[103:88]};
               item_in.sample_count = req_tdata[119:104];
               item_in.sample_rate_mhz = req_tdata[151:120];
               item_in.current_time_us = req_tdata[214:152];
               scan_in = '0;
               created_in = 1'b0;
               if (req_tdata[119:104] == 16'd0 || req_tdata[151:120] == '0) begin
                  fin_in.start_time_us = '0;
                  fin_in.end_time_us = '0;
                  fin_in.status = ST_INVALID;
                  fin_in.entry_created = 1'b0;
                  state_in = S_OUT;
               end else begin
                  state_in = S_SEARCH;
               end
            end
         end
         S_SEARCH: begin
            // issue read of entry scan_ff; result checked next cycle
            if (scan_ff >= used_ff) begin
               if (used_ff >= CNT_W'(TABLE_DEPTH)) begin
                  fin_in.start_time_us = '0;
                  fin_in.end_time_us = '0;
                  fin_in.status = ST_FULL;
                  fin_in.entry_created = 1'b0;
                  state_in = S_OUT;
               end else begin
                  slot_in = used_ff[IDX_W-1:0];
                  key_wr = 1'b1;
                  mem_we = 1'b1;
                  wr_addr = used_ff[IDX_W-1:0];
                  used_in = used_ff + 1'b1;
                  created_in = 1'b1;
                  num_in = prod;
                  rem_in = '0;
                  quo_in = '0;
                  step_in = '0;
                  state_in = S_DIV;
               end
            end else begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (sta_rd_ff == item_ff.station_code && oth_rd_ff == item_ff.other_code) begin
               slot_in = scan_ff[IDX_W-1:0];
               num_in = prod;
               rem_in = '0;
               quo_in = '0;
               step_in = '0;
               state_in = S_DIV;
            end else begin
               scan_in = scan_ff + 1'b1;
               state_in = S_SEARCH;
            end
         end
         S_DIV: begin
            num_in = {num_ff[NUM_W-2:0], 1'b0};
            if (rem_sh >= {1'b0, item_ff.sample_rate_mhz}) begin
               rem_in = rem_sh - {1'b0, item_ff.sample_rate_mhz};
               quo_in = {quo_ff[NUM_W-2:0], 1'b1};
            end else begin
               rem_in = rem_sh;
               quo_in = {quo_ff[NUM_W-2:0], 1'b0};
            end
            step_in = step_ff + 1'b1;
            rd_addr = slot_ff;
            if (step_ff == 6'(NUM_W - 1)) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            rd_addr = slot_ff;
            state_in = S_WRITE;
         end
         S_WRITE: begin
            fin_in.start_time_us = time_rd_ff;
            fin_in.end_time_us = end_sum[TIME_W] ? TIME_MAX : end_sum[TIME_W-1:0];
            fin_in.status = ST_OK;
            fin_in.entry_created = created_ff;
            mem_we = 1'b1;
            wr_addr = slot_ff;
            wr_time = fin_in.end_time_us;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               res_in = fin_ff;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      rd_pending_in = (state_ff == S_SEARCH);
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         time_mem[wr_addr] <= wr_time;
      end
      if (key_wr) begin
         sta_mem[wr_addr] <= item_ff.station_code;
         oth_mem[wr_addr] <= item_ff.other_code;
      end
      sta_rd_ff <= sta_mem[rd_addr];
      oth_rd_ff <= oth_mem[rd_addr];
      time_rd_ff <= time_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         used_ff <= '0;
         rd_pending_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         used_ff <= used_in;
         rd_pending_ff <= rd_pending_in;
      end
      item_ff <= item_in;
      res_ff <= res_in;
      fin_ff <= fin_in;
      scan_ff <= scan_in;
      slot_ff <= slot_in;
      created_ff <= created_in;
      quo_ff <= quo_in;
      num_ff <= num_in;
      rem_ff <= rem_in;
      step_ff <= step_in;
   end

`ifndef ASSERT_OFF
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= CNT_W'(TABLE_DEPTH)) else $error("entry count overflow");
   a_check_after_read: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CHECK |-> rd_pending_ff) else $error("compare without read");
   a_used_step: assert property (@(posedge clock) disable iff (reset)
      used_ff != $past(used_ff) |-> used_ff == $past(used_ff) + 1'b1)
      else $error("entry count jumped");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response dropped");
`endif
endmodule
